@@ rtl/dfl_pkg.sv @@
package dfl_pkg;

  // Table sizes and key layout.
  localparam int unsigned RECENT_DEPTH    = 1024;
  localparam int unsigned GLOBAL_DEPTH    = 4096;
  localparam int unsigned RECENT_ID_SHIFT = 2;
  localparam int unsigned GLOBAL_ID_SHIFT = 24;
  localparam int unsigned FILE_POS_BITS   = 16;

  // Field widths.
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DOC_W   = 38;
  localparam int unsigned FNUM_W  = 16;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned WHERE_W = 2;

  // Address and count widths derived from the table depths.
  localparam int unsigned RECENT_AW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam int unsigned GLOBAL_AW = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
  localparam int unsigned RECENT_CW = $clog2(RECENT_DEPTH + 1);
  localparam int unsigned GLOBAL_CW = $clog2(GLOBAL_DEPTH + 1);
  localparam int unsigned SRCH_W    = (RECENT_CW > GLOBAL_CW) ? RECENT_CW : GLOBAL_CW;

  // Width used to compare a file position against a file number.
  localparam int unsigned PCMP_W = (FILE_POS_BITS > FNUM_W) ? FILE_POS_BITS : FNUM_W;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_W  = 120;
  localparam int unsigned OUT_W = 24;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_QUERY      = 2'd0;
  localparam logic [OP_W-1:0] OP_APP_RECENT = 2'd1;
  localparam logic [OP_W-1:0] OP_APP_GLOBAL = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR      = 2'd3;

  // Where a query found its document.
  localparam logic [WHERE_W-1:0] WHERE_RECENT = 2'd0;
  localparam logic [WHERE_W-1:0] WHERE_GLOBAL = 2'd1;
  localparam logic [WHERE_W-1:0] WHERE_NONE   = 2'd2;

endpackage

@@ rtl/dfl_ram.sv @@
module dfl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/docid_file_locator.sv @@
// A request is taken only while the block is idle, so the block works on one request at a
// time. A query runs a binary search of the recent table and, on a miss, of the global
// table; its pace is set by the one shared key comparator and the registered read of each
// table RAM. The result is registered at the edge that makes the block ready again; a
// stalled result holds the block. Reset (rst_ni low, asynchronous) empties both tables
// and sets num_files to 0.
module docid_file_locator
  import dfl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: num_files.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [15:0]      cfg_data_i,
  // Request stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // doc_id [37:0], file_num [53:38], merging [54], table_key [118:55], zero [119]
  input  logic [IN_W-1:0]  s_axis_tdata,
  // op [1:0]
  input  logic [OP_W-1:0]  s_axis_tuser,
  // Result stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // file_pos [15:0], in_file [16], found_where [18:17], merge_miss [19],
  // status [20], zero [23:21]
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPEND = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_CMP    = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [OP_W-1:0]      op_q, op_d;
  logic [DOC_W-1:0]     doc_q, doc_d;
  logic [FNUM_W-1:0]    fnum_q, fnum_d;
  logic                 merging_q, merging_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic                 tbl_q, tbl_d;
  logic [SRCH_W-1:0]    lo_q, lo_d, hi_q, hi_d, n_q, n_d, mid_q, mid_d;
  logic [RECENT_CW-1:0] r_cnt_q, r_cnt_d;
  logic [GLOBAL_CW-1:0] g_cnt_q, g_cnt_d;
  logic [KEY_W-1:0]     r_last_q, r_last_d, g_last_q, g_last_d;
  logic [15:0]          num_files_q;
  logic [POS_W-1:0]     res_pos_q, res_pos_d;
  logic                 res_inf_q, res_inf_d;
  logic [WHERE_W-1:0]   res_where_q, res_where_d;
  logic                 res_miss_q, res_miss_d;
  logic                 res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     out_data_q, out_data_d;

  logic                 s_fire;
  logic [SRCH_W-1:0]    mid_calc, rd_idx;
  logic [KEY_W-1:0]     r_rdata, g_rdata, rd_key, target, last_key;
  logic [KEY_W-1:0]     cmp_a, cmp_b;
  logic                 key_lt, key_hit;
  logic                 app_full, app_nonempty, app_reject;
  logic                 r_we, g_we;
  logic                 tbl_miss;
  logic [PCMP_W-1:0]    gpos;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Midpoint of the open search interval and the table index to read.
  assign mid_calc = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_idx   = (lo_q < hi_q) ? mid_calc : lo_q;

  // Key tables.
  dfl_ram #(.WIDTH(KEY_W), .DEPTH(RECENT_DEPTH)) u_recent_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_cnt_q[RECENT_AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (rd_idx[RECENT_AW-1:0]),
    .rdata_o (r_rdata)
  );

  dfl_ram #(.WIDTH(KEY_W), .DEPTH(GLOBAL_DEPTH)) u_global_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_cnt_q[GLOBAL_AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (rd_idx[GLOBAL_AW-1:0]),
    .rdata_o (g_rdata)
  );

  // Shared key comparator: search probes against the target, appends
  // against the last key of the table.
  assign rd_key   = tbl_q ? g_rdata : r_rdata;
  assign target   = tbl_q ? (KEY_W'(doc_q) << GLOBAL_ID_SHIFT)
                          : (KEY_W'(doc_q) << RECENT_ID_SHIFT);
  assign last_key = (op_q == OP_APP_RECENT) ? r_last_q : g_last_q;
  assign cmp_a    = (state_q == ST_APPEND) ? key_q : rd_key;
  assign cmp_b    = (state_q == ST_APPEND) ? last_key : target;
  assign key_lt   = cmp_a < cmp_b;

  // A probed key is a hit when its id part equals the document id.
  assign key_hit = tbl_q ? ((rd_key >> GLOBAL_ID_SHIFT) == KEY_W'(doc_q))
                         : ((rd_key >> RECENT_ID_SHIFT) == KEY_W'(doc_q));

  // File position held in the low bits of a global key.
  assign gpos = PCMP_W'(rd_key[FILE_POS_BITS-1:0]);

  // Append checks: full table or key below the last one.
  assign app_full     = (op_q == OP_APP_RECENT) ? (r_cnt_q >= RECENT_CW'(RECENT_DEPTH))
                                                : (g_cnt_q >= GLOBAL_CW'(GLOBAL_DEPTH));
  assign app_nonempty = (op_q == OP_APP_RECENT) ? (r_cnt_q != '0) : (g_cnt_q != '0);
  assign app_reject   = app_full || (app_nonempty && key_lt);
  assign r_we = (state_q == ST_APPEND) && (op_q == OP_APP_RECENT) && !app_reject;
  assign g_we = (state_q == ST_APPEND) && (op_q == OP_APP_GLOBAL) && !app_reject;

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    doc_d        = doc_q;
    fnum_d       = fnum_q;
    merging_d    = merging_q;
    key_d        = key_q;
    tbl_d        = tbl_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    n_d          = n_q;
    mid_d        = mid_q;
    r_cnt_d      = r_cnt_q;
    g_cnt_d      = g_cnt_q;
    r_last_d     = r_last_q;
    g_last_d     = g_last_q;
    res_pos_d    = res_pos_q;
    res_inf_d    = res_inf_q;
    res_where_d  = res_where_q;
    res_miss_d   = res_miss_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    tbl_miss     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          op_d         = s_axis_tuser;
          doc_d        = s_axis_tdata[37:0];
          fnum_d       = s_axis_tdata[53:38];
          merging_d    = s_axis_tdata[54];
          key_d        = s_axis_tdata[118:55];
          res_pos_d    = '0;
          res_inf_d    = 1'b0;
          res_where_d  = WHERE_RECENT;
          res_miss_d   = 1'b0;
          res_status_d = 1'b0;
          case (s_axis_tuser)
            OP_QUERY: begin
              tbl_d   = 1'b0;
              lo_d    = '0;
              hi_d    = SRCH_W'(r_cnt_q);
              n_d     = SRCH_W'(r_cnt_q);
              state_d = ST_SEARCH;
            end
            OP_APP_RECENT, OP_APP_GLOBAL: begin
              state_d = ST_APPEND;
            end
            default: begin
              r_cnt_d = '0;
              g_cnt_d = '0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_APPEND: begin
        res_status_d = app_reject;
        if (r_we) begin
          r_cnt_d  = r_cnt_q + RECENT_CW'(1);
          r_last_d = key_q;
        end
        if (g_we) begin
          g_cnt_d  = g_cnt_q + GLOBAL_CW'(1);
          g_last_d = key_q;
        end
        state_d = ST_DONE;
      end
      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_calc;
          state_d = ST_CMP;
        end else if (lo_q < n_q) begin
          state_d = ST_CHECK;
        end else begin
          tbl_miss = 1'b1;
        end
      end
      ST_CMP: begin
        if (key_lt) begin
          lo_d = mid_q + SRCH_W'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_SEARCH;
      end
      ST_CHECK: begin
        if (key_hit) begin
          if (tbl_q) begin
            res_pos_d   = gpos[POS_W-1:0];
            res_inf_d   = (gpos == PCMP_W'(fnum_q));
            res_where_d = WHERE_GLOBAL;
          end else begin
            res_pos_d   = num_files_q;
            res_inf_d   = (fnum_q == num_files_q);
            res_where_d = WHERE_RECENT;
          end
          state_d = ST_DONE;
        end else begin
          tbl_miss = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, res_status_q, res_miss_q, res_where_q, res_inf_q,
                         res_pos_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A miss in the recent table moves on to the global one; a miss there
    // ends the query.
    if (tbl_miss) begin
      if (!tbl_q) begin
        tbl_d   = 1'b1;
        lo_d    = '0;
        hi_d    = SRCH_W'(g_cnt_q);
        n_d     = SRCH_W'(g_cnt_q);
        state_d = ST_SEARCH;
      end else begin
        res_pos_d   = num_files_q;
        res_inf_d   = 1'b0;
        res_where_d = WHERE_NONE;
        res_miss_d  = merging_q;
        state_d     = ST_DONE;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r_cnt_q     <= '0;
      g_cnt_q     <= '0;
      num_files_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      r_cnt_q     <= r_cnt_d;
      g_cnt_q     <= g_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_files_q <= cfg_data_i;
      end
    end
  end

  // Payload and search registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    doc_q        <= doc_d;
    fnum_q       <= fnum_d;
    merging_q    <= merging_d;
    key_q        <= key_d;
    tbl_q        <= tbl_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    n_q          <= n_d;
    mid_q        <= mid_d;
    r_last_q     <= r_last_d;
    g_last_q     <= g_last_d;
    res_pos_q    <= res_pos_d;
    res_inf_q    <= res_inf_d;
    res_where_q  <= res_where_d;
    res_miss_q   <= res_miss_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
  end

  // Fill counts never pass the table depths.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_cnt_q <= RECENT_CW'(RECENT_DEPTH)) && (g_cnt_q <= GLOBAL_CW'(GLOBAL_DEPTH)))
    else $error("table fill count beyond depth");

  // The search interval stays inside the filled part of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (lo_q <= hi_q) && (hi_q <= n_q))
    else $error("search interval out of range");

  // A probe only reads a filled entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP || state_q == ST_CHECK) |-> (rd_idx < n_q || state_q == ST_CMP))
    else $error("final probe beyond fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (mid_q < n_q))
    else $error("midpoint probe beyond fill count");

  // An accepted query request starts a search in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser == OP_QUERY) |=> (state_q == ST_SEARCH && !tbl_q))
    else $error("query did not start in the recent table");

endmodule

@@ tb/tb_docid_file_locator.sv @@
module tb_docid_file_locator;
  timeunit 1ns;
  timeprecision 1ps;
  import dfl_pkg::*;

  localparam logic [DOC_W-1:0] DOC_MAX = '1;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned FILL_RECENT = 48;
  localparam int unsigned FILL_GLOBAL = 64;

  // One expected result of the locator.
  typedef struct packed {
    logic [POS_W-1:0]   file_pos;
    logic               in_file;
    logic [WHERE_W-1:0] found_where;
    logic               merge_miss;
    logic               status;
  } locate_res_t;

  // Scoreboard: mirrors both key tables and holds the expected results in order.
  class locator_scoreboard;
    logic [KEY_W-1:0]  recent_tab [RECENT_DEPTH];
    logic [KEY_W-1:0]  global_tab [GLOBAL_DEPTH];
    int unsigned       recent_fill;
    int unsigned       global_fill;
    logic [FNUM_W-1:0] files_reg;
    locate_res_t       expected_locs [$];
    int unsigned       fail_count;

    function new();
      recent_fill = 0;
      global_fill = 0;
      files_reg   = '0;
      fail_count  = 0;
    endfunction

    function void set_num_files(logic [FNUM_W-1:0] value);
      files_reg = value;
    endfunction

    function int unsigned pending();
      return expected_locs.size();
    endfunction

    // Lower-bound search for doc << shift; a hit needs key >> shift == doc.
    function bit find_key(bit in_global, logic [DOC_W-1:0] doc,
                          output logic [KEY_W-1:0] found);
      int unsigned lo, hi, mid, n, sh;
      logic [KEY_W-1:0] target, probe;
      n  = in_global ? global_fill : recent_fill;
      sh = in_global ? GLOBAL_ID_SHIFT : RECENT_ID_SHIFT;
      target = {{(KEY_W-DOC_W){1'b0}}, doc} << sh;
      lo = 0;
      hi = n;
      found = '0;
      while (lo < hi) begin
        mid   = lo + (hi - lo) / 2;
        probe = in_global ? global_tab[mid] : recent_tab[mid];
        if (probe < target) lo = mid + 1;
        else hi = mid;
      end
      if (lo >= n) return 1'b0;
      found = in_global ? global_tab[lo] : recent_tab[lo];
      return (found >> sh) == {{(KEY_W-DOC_W){1'b0}}, doc};
    endfunction

    // Append keeps the table sorted; a full table or a smaller key is refused.
    function logic add_key(bit in_global, logic [KEY_W-1:0] tkey);
      int unsigned n, depth;
      logic [KEY_W-1:0] last_key;
      n     = in_global ? global_fill : recent_fill;
      depth = in_global ? GLOBAL_DEPTH : RECENT_DEPTH;
      if (n >= depth) return 1'b1;
      if (n > 0) begin
        last_key = in_global ? global_tab[n-1] : recent_tab[n-1];
        if (tkey < last_key) return 1'b1;
      end
      if (in_global) begin
        global_tab[n] = tkey;
        global_fill   = n + 1;
      end else begin
        recent_tab[n] = tkey;
        recent_fill   = n + 1;
      end
      return 1'b0;
    endfunction

    // Work out the result of one accepted request and queue it.
    function void note_request(logic [OP_W-1:0] op, logic [DOC_W-1:0] doc,
                               logic [FNUM_W-1:0] fnum, logic merging,
                               logic [KEY_W-1:0] tkey);
      locate_res_t r;
      logic [KEY_W-1:0] hit_key;
      r = '0;
      case (op)
        OP_QUERY: begin
          if (find_key(1'b0, doc, hit_key)) begin
            r.file_pos    = files_reg;
            r.in_file     = (fnum == files_reg);
            r.found_where = WHERE_RECENT;
          end else if (find_key(1'b1, doc, hit_key)) begin
            r.file_pos    = hit_key[POS_W-1:0];
            r.in_file     = (hit_key[FILE_POS_BITS-1:0] == fnum);
            r.found_where = WHERE_GLOBAL;
          end else begin
            r.file_pos    = files_reg;
            r.found_where = WHERE_NONE;
            r.merge_miss  = merging;
          end
        end
        OP_APP_RECENT: r.status = add_key(1'b0, tkey);
        OP_APP_GLOBAL: r.status = add_key(1'b1, tkey);
        OP_CLEAR: begin
          recent_fill = 0;
          global_fill = 0;
        end
      endcase
      expected_locs.push_back(r);
    endfunction

    function void report_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        fail_count++;
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [OUT_W-1:0] data);
      locate_res_t exp_r, act_r;
      if (expected_locs.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, data);
        fail_count++;
        return;
      end
      exp_r = expected_locs.pop_front();
      act_r.file_pos    = data[15:0];
      act_r.in_file     = data[16];
      act_r.found_where = data[18:17];
      act_r.merge_miss  = data[19];
      act_r.status      = data[20];
      report_field("file_pos", 16'(exp_r.file_pos), 16'(act_r.file_pos));
      report_field("in_file", 16'(exp_r.in_file), 16'(act_r.in_file));
      report_field("found_where", 16'(exp_r.found_where), 16'(act_r.found_where));
      report_field("merge_miss", 16'(exp_r.merge_miss), 16'(act_r.merge_miss));
      report_field("status", 16'(exp_r.status), 16'(act_r.status));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready_o;
  logic [15:0]      cfg_data = '0;
  logic             s_valid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_data = '0;
  logic [OP_W-1:0]  s_user = '0;
  logic             m_axis_tvalid;
  logic             m_ready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  locator_scoreboard sb;
  int unsigned       src_idle = 0;
  int unsigned       snk_stall = 0;
  int unsigned       items_sent = 0;
  int unsigned       quiet_cycles = 0;
  logic [FNUM_W-1:0] cur_files = '0;

  docid_file_locator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5ns clk_i = ~clk_i;

  // Result side stalls at random according to the current phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_ready <= 1'b0;
    else m_ready <= ($urandom_range(99) >= snk_stall);
  end

  // Check every result taken by the receiver.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) sb.check_result(m_axis_tdata);
  end

  // Watchdog on cycles where no handshake completes anywhere.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one request, with random idle cycles first; valid stays high after acceptance.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [DOC_W-1:0] doc,
                              input logic [FNUM_W-1:0] fnum, input logic merging,
                              input logic [KEY_W-1:0] tkey);
    while ($urandom_range(99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, tkey, merging, fnum, doc};
    s_user  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, doc, fnum, merging, tkey);
    items_sent++;
  endtask

  // Request with random don't-care fields.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] tkey);
    logic [63:0] r;
    r = rand64();
    send_request(op, r[37:0], r[53:38], r[54], tkey);
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic wait_drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_num_files(input logic [FNUM_W-1:0] value);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    sb.set_num_files(value);
    cur_files = value;
  endtask

  // Clear, load longer sorted runs into both tables, query them, then clear again.
  task automatic fill_tables();
    logic [63:0] r;
    logic [DOC_W-1:0] rbase, gbase, q_doc;
    logic [KEY_W-1:0] tkey;
    r = rand64();
    rbase = {8'd0, r[29:0]};
    gbase = {8'd0, r[61:32]};
    send_op(OP_CLEAR, rand64());
    for (int i = 0; i < FILL_RECENT; i++) begin
      tkey = ({26'd0, rbase + DOC_W'(i)} << RECENT_ID_SHIFT) | 64'($urandom_range(3));
      send_op(OP_APP_RECENT, tkey);
    end
    for (int i = 0; i < FILL_GLOBAL; i++) begin
      tkey = ({26'd0, gbase + DOC_W'(i)} << GLOBAL_ID_SHIFT) | 64'($urandom_range(24'hFFFFFF));
      send_op(OP_APP_GLOBAL, tkey);
    end
    repeat (24) begin
      r = rand64();
      q_doc = $urandom_range(1) ? rbase + DOC_W'($urandom_range(FILL_RECENT))
                                : gbase + DOC_W'($urandom_range(FILL_GLOBAL));
      send_request(OP_QUERY, q_doc, r[15:0], r[16], rand64());
    end
    send_op(OP_CLEAR, rand64());
  endtask

  // Mostly a clear, a sorted load of both tables and queries aimed at the keys;
  // sometimes plain noise.
  task automatic run_sequence();
    logic [63:0] r;
    logic [DOC_W-1:0] doc_r, doc_g, q_doc;
    logic [FNUM_W-1:0] fnum;
    logic [KEY_W-1:0] tkey;
    logic [DOC_W-1:0] rdocs [$];
    logic [KEY_W-1:0] gkeys [$];
    int nr, ng, pick;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(8, 3)) begin
        r = rand64();
        send_request(r[1:0], r[39:2], r[55:40], r[56], rand64());
      end
      return;
    end
    r = rand64();
    doc_r = r[37:0];
    if (doc_r > DOC_MAX - 512) doc_r = doc_r - 512;
    r = rand64();
    doc_g = $urandom_range(1) ? doc_r : r[37:0];
    if (doc_g > DOC_MAX - 512) doc_g = doc_g - 512;
    send_op(OP_CLEAR, rand64());
    nr = $urandom_range(12);
    ng = $urandom_range(16);
    while (nr > 0 || ng > 0) begin
      if ($urandom_range(99) < 6) begin
        // A stray append, often out of order.
        r = rand64();
        send_op($urandom_range(1) ? OP_APP_RECENT : OP_APP_GLOBAL, r >> $urandom_range(63));
        nr = (nr > 0) ? nr - 1 : 0;
      end else if (nr > 0 && (ng == 0 || $urandom_range(1))) begin
        doc_r = doc_r + DOC_W'($urandom_range(3));
        tkey = ({26'd0, doc_r} << RECENT_ID_SHIFT) | 64'($urandom_range(3));
        rdocs.push_back(doc_r);
        send_op(OP_APP_RECENT, tkey);
        nr--;
      end else begin
        doc_g = doc_g + DOC_W'($urandom_range(3));
        r = rand64();
        pick = $urandom_range(3);
        if (pick == 0) r[15:0] = '0;
        else if (pick == 1) r[15:0] = '1;
        tkey = ({26'd0, doc_g} << GLOBAL_ID_SHIFT) | {40'd0, r[23:0]};
        gkeys.push_back(tkey);
        send_op(OP_APP_GLOBAL, tkey);
        ng--;
      end
    end
    // Now and then let the block run dry before the queries.
    if ($urandom_range(9) == 0) wait_drain();
    repeat ($urandom_range(12, 3)) begin
      r = rand64();
      q_doc = r[37:0];
      fnum  = r[53:38];
      pick  = $urandom_range(9);
      if (pick < 3 && rdocs.size() > 0) begin
        q_doc = rdocs[$urandom_range(rdocs.size() - 1)];
      end else if (pick < 6 && gkeys.size() > 0) begin
        tkey  = gkeys[$urandom_range(gkeys.size() - 1)];
        q_doc = tkey[GLOBAL_ID_SHIFT +: DOC_W];
        if ($urandom_range(1)) fnum = tkey[FNUM_W-1:0];
      end else if (pick < 8) begin
        q_doc = ($urandom_range(1) ? doc_r : doc_g) + DOC_W'($urandom_range(2)) - 1;
      end
      if ($urandom_range(3) == 0) fnum = cur_files;
      send_request(OP_QUERY, q_doc, fnum, r[60], rand64());
    end
  endtask

  initial begin
    int unsigned target;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: empty tables, edge keys, ordering and every outcome.
    write_num_files(16'h0000);
    send_request(OP_QUERY, '0, '0, 1'b1, '0);
    send_request(OP_QUERY, DOC_MAX, '1, 1'b0, '1);
    send_request(OP_CLEAR, '0, '0, 1'b0, '0);
    write_num_files(16'hFFFF);
    send_request(OP_APP_RECENT, DOC_MAX, '1, 1'b1, 64'd0);
    send_request(OP_APP_RECENT, '0, '0, 1'b0, (64'd10 << RECENT_ID_SHIFT) | 64'd3);
    send_request(OP_APP_RECENT, '0, '0, 1'b0, (64'd10 << RECENT_ID_SHIFT) | 64'd3);
    send_request(OP_APP_RECENT, '0, '0, 1'b0, 64'd5);
    send_request(OP_APP_RECENT, '0, '0, 1'b0, 64'h0000_00FF_FFFF_FFFF);
    send_request(OP_APP_GLOBAL, '0, '0, 1'b0, 64'd5 << GLOBAL_ID_SHIFT);
    send_request(OP_APP_GLOBAL, '0, '0, 1'b0, (64'd10 << GLOBAL_ID_SHIFT) | 64'hABCD);
    send_request(OP_APP_GLOBAL, '0, '0, 1'b0, (64'd20 << GLOBAL_ID_SHIFT) | 64'hFF_FFFF);
    send_request(OP_APP_GLOBAL, '0, '0, 1'b0, '1);
    send_request(OP_APP_GLOBAL, '0, '0, 1'b0, 64'd1);
    send_request(OP_QUERY, 38'd0, 16'hFFFF, 1'b1, '0);
    send_request(OP_QUERY, 38'd10, 16'h0000, 1'b1, '0);
    send_request(OP_QUERY, 38'd5, 16'h0000, 1'b1, '0);
    send_request(OP_QUERY, 38'd20, 16'hFFFF, 1'b0, '0);
    send_request(OP_QUERY, 38'd21, 16'hFFFF, 1'b1, '0);
    send_request(OP_QUERY, DOC_MAX, 16'h1234, 1'b0, '0);
    send_request(OP_QUERY, 38'd1, 16'h0000, 1'b0, '0);
    send_request(OP_CLEAR, DOC_MAX, '1, 1'b1, '1);
    send_request(OP_QUERY, 38'd0, 16'hFFFF, 1'b1, '0);

    // Longer tables, with light idling on both sides.
    write_num_files(16'($urandom));
    src_idle  = 13;
    snk_stall = 13;
    fill_tables();

    // Random phases, each with its own idling on the two sides.
    target = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle = 0;  snk_stall = 0;  write_num_files(16'h0000); end
        1: begin src_idle = 55; snk_stall = 0;  write_num_files(16'hFFFF); end
        2: begin src_idle = 0;  snk_stall = 55; write_num_files(16'($urandom)); end
        default: begin src_idle = 13; snk_stall = 13; write_num_files(16'($urandom)); end
      endcase
      target = target + ITEMS_PER_PHASE;
      while (items_sent < target) run_sequence();
    end

    // Drain and let the block settle before the verdict.
    wait_drain();
    repeat (60) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
